FILE: rtl/fsgs_pkg.sv
// ----------------------------------------------------------------------------
// fsgs_pkg
// Shared types, sizes and codes for the falling-sand grid sweep unit.
// ----------------------------------------------------------------------------
package fsgs_pkg;

  localparam int ROWS   = 64;
  localparam int COLS   = 64;
  localparam int DEPTH  = ROWS * COLS;
  localparam int ROW_W  = $clog2(ROWS);
  localparam int COL_W  = $clog2(COLS);
  localparam int ADDR_W = $clog2(DEPTH);

  // Operation codes.
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_SWEEP = 2'd2;

  // Cell kinds.
  localparam logic [1:0] KIND_EMPTY  = 2'd0;
  localparam logic [1:0] KIND_SAND   = 2'd1;
  localparam logic [1:0] KIND_WATER  = 2'd2;
  localparam logic [1:0] KIND_STATIC = 2'd3;

  // Neighbor selection relative to the sweep position.
  localparam logic [2:0] DIR_CENTER = 3'd0;
  localparam logic [2:0] DIR_DOWN   = 3'd1;
  localparam logic [2:0] DIR_DL     = 3'd2;
  localparam logic [2:0] DIR_DR     = 3'd3;
  localparam logic [2:0] DIR_LEFT   = 3'd4;
  localparam logic [2:0] DIR_RIGHT  = 3'd5;

  // Memory address source.
  localparam logic [1:0] SRC_CELL  = 2'd0;
  localparam logic [1:0] SRC_HOST  = 2'd1;
  localparam logic [1:0] SRC_CLEAR = 2'd2;

  typedef struct packed {
    logic [1:0] operation;
    logic [5:0] row;
    logic [5:0] column;
    logic [1:0] cell_kind;
  } in_item_t;

  typedef struct packed {
    logic [1:0] read_kind;
    logic [1:0] finished_operation;
  } out_item_t;

  typedef struct packed {
    logic       load;        // latch the accepted item
    logic       sw_init;     // place the sweep at the bottom-left cell
    logic       sw_adv;      // step the sweep to the next cell
    logic       clr_inc;     // step the clearing pass
    logic [1:0] asel;        // address source
    logic [2:0] dir;         // neighbor for the cell address
    logic       we;          // memory write
    logic       wfrom_host;  // write data from the item instead of wkind
    logic [1:0] wkind;       // write data for sweep and clear writes
    logic       finish;      // present a result next cycle
    logic       take_read;   // result carries the memory read data
  } dp_cmd_t;

  typedef struct packed {
    logic       clr_last;
    logic       sw_last;
    logic       in_down;
    logic       in_left;
    logic       in_right;
    logic       host_inside;
    logic [1:0] rd_kind;
  } dp_status_t;

endpackage

FILE: rtl/fsgs_ram.sv
// ----------------------------------------------------------------------------
// fsgs_ram
// Generic single-port RAM with a registered read.
// ----------------------------------------------------------------------------
module fsgs_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: rtl/fsgs_dpath.sv
// ----------------------------------------------------------------------------
// fsgs_dpath
// Datapath: item register, sweep and clear counters, address and write data
// selection, the cell memory and the result register.
// ----------------------------------------------------------------------------
module fsgs_dpath (
  input  logic                  clk,
  input  logic                  rst_n,
  input  fsgs_pkg::in_item_t    in_item,
  input  fsgs_pkg::dp_cmd_t     cmd,
  output fsgs_pkg::dp_status_t  status,
  output logic                  out_valid,
  output fsgs_pkg::out_item_t   out_item
);
  import fsgs_pkg::*;

  in_item_t          item_r;
  logic [ROW_W-1:0]  row_r;
  logic [COL_W-1:0]  col_r;
  logic [ADDR_W-1:0] clr_r;
  logic              out_valid_r;
  out_item_t         out_r;

  logic [ROW_W-1:0]  nrow;
  logic [COL_W-1:0]  ncol;
  logic [ADDR_W-1:0] cell_addr;
  logic [ADDR_W-1:0] host_addr;
  logic [ADDR_W-1:0] addr;
  logic [1:0]        wdata;
  logic [1:0]        rd_kind;
  logic              col_end;

  assign col_end = (col_r == COL_W'(COLS - 1));

  always_comb begin
    nrow = row_r;
    ncol = col_r;
    unique case (cmd.dir)
      DIR_CENTER: ;
      DIR_DOWN:   nrow = row_r + ROW_W'(1);
      DIR_DL: begin
        nrow = row_r + ROW_W'(1);
        ncol = col_r - COL_W'(1);
      end
      DIR_DR: begin
        nrow = row_r + ROW_W'(1);
        ncol = col_r + COL_W'(1);
      end
      DIR_LEFT:   ncol = col_r - COL_W'(1);
      DIR_RIGHT:  ncol = col_r + COL_W'(1);
      default: ;
    endcase
  end

  // Out-of-grid neighbors may alias other cells; the controller masks them.
  assign cell_addr = ADDR_W'(ADDR_W'(nrow) * ADDR_W'(COLS) + ADDR_W'(ncol));
  assign host_addr = ADDR_W'(ADDR_W'(item_r.row) * ADDR_W'(COLS)
                             + ADDR_W'(item_r.column));

  always_comb begin
    unique case (cmd.asel)
      SRC_CELL:  addr = cell_addr;
      SRC_HOST:  addr = host_addr;
      SRC_CLEAR: addr = clr_r;
      default:   addr = cell_addr;
    endcase
  end

  assign wdata = cmd.wfrom_host ? item_r.cell_kind : cmd.wkind;

  fsgs_ram #(
    .WIDTH(2),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (cmd.we),
    .addr (addr),
    .wdata(wdata),
    .rdata(rd_kind)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.finish;
      if (cmd.clr_inc) begin
        clr_r <= clr_r + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_item;
    end
    if (cmd.sw_init) begin
      row_r <= ROW_W'(ROWS - 1);
      col_r <= '0;
    end else if (cmd.sw_adv) begin
      if (col_end) begin
        col_r <= '0;
        row_r <= row_r - ROW_W'(1);
      end else begin
        col_r <= col_r + COL_W'(1);
      end
    end
    if (cmd.finish) begin
      out_r.read_kind          <= cmd.take_read ? rd_kind : KIND_EMPTY;
      out_r.finished_operation <= item_r.operation;
    end
  end

  assign status.clr_last    = (clr_r == ADDR_W'(DEPTH - 1));
  assign status.sw_last     = (row_r == '0) && col_end;
  assign status.in_down     = (row_r != ROW_W'(ROWS - 1));
  assign status.in_left     = (col_r != '0);
  assign status.in_right    = !col_end;
  assign status.host_inside = (32'(item_r.row) < ROWS) && (32'(item_r.column) < COLS);
  assign status.rd_kind     = rd_kind;

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

FILE: rtl/fsgs_ctrl.sv
// ----------------------------------------------------------------------------
// fsgs_ctrl
// Controller: clearing pass, host read and write, and the per-cell probe
// sequence of a sweep.
// ----------------------------------------------------------------------------
module fsgs_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [1:0]            in_op,
  input  fsgs_pkg::dp_status_t  status,
  output fsgs_pkg::dp_cmd_t     cmd,
  output logic                  busy
);
  import fsgs_pkg::*;

  localparam logic [3:0] ST_CLEAR  = 4'd0;
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_HWR    = 4'd2;
  localparam logic [3:0] ST_HRD    = 4'd3;
  localparam logic [3:0] ST_HRDATA = 4'd4;
  localparam logic [3:0] ST_DONE   = 4'd5;
  localparam logic [3:0] ST_FETCH  = 4'd6;
  localparam logic [3:0] ST_CENTER = 4'd7;
  localparam logic [3:0] ST_DOWN   = 4'd8;
  localparam logic [3:0] ST_LEFT   = 4'd9;
  localparam logic [3:0] ST_RIGHT  = 4'd10;
  localparam logic [3:0] ST_DL     = 4'd11;
  localparam logic [3:0] ST_DR     = 4'd12;
  localparam logic [3:0] ST_MOVE   = 4'd13;
  localparam logic [3:0] ST_PLACE  = 4'd14;
  localparam logic [3:0] ST_NEXT   = 4'd15;

  logic [3:0] state_r, state_nxt;
  logic [1:0] kind_r, kind_nxt;
  logic [2:0] tgt_r, tgt_nxt;
  logic       lfree_r, lfree_nxt;
  logic       rd_empty;

  assign rd_empty = (status.rd_kind == KIND_EMPTY);
  assign busy     = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    tgt_nxt   = tgt_r;
    lfree_nxt = lfree_r;
    cmd       = '0;
    cmd.asel  = SRC_CELL;
    cmd.dir   = DIR_CENTER;
    cmd.wkind = KIND_EMPTY;

    unique case (state_r)
      ST_CLEAR: begin
        cmd.asel    = SRC_CLEAR;
        cmd.we      = 1'b1;
        cmd.clr_inc = 1'b1;
        if (status.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          cmd.load    = 1'b1;
          cmd.sw_init = 1'b1;
          unique case (in_op)
            OP_WRITE: state_nxt = ST_HWR;
            OP_READ:  state_nxt = ST_HRD;
            OP_SWEEP: state_nxt = ST_FETCH;
            default:  state_nxt = ST_DONE;
          endcase
        end
      end
      ST_HWR: begin
        cmd.asel       = SRC_HOST;
        cmd.we         = status.host_inside;
        cmd.wfrom_host = 1'b1;
        cmd.finish     = 1'b1;
        state_nxt      = ST_IDLE;
      end
      ST_HRD: begin
        cmd.asel  = SRC_HOST;
        state_nxt = ST_HRDATA;
      end
      ST_HRDATA: begin
        cmd.finish    = 1'b1;
        cmd.take_read = status.host_inside;
        state_nxt     = ST_IDLE;
      end
      ST_DONE: begin
        cmd.finish = 1'b1;
        state_nxt  = ST_IDLE;
      end
      ST_FETCH: begin
        cmd.dir   = DIR_CENTER;
        state_nxt = ST_CENTER;
      end
      ST_CENTER: begin
        kind_nxt = status.rd_kind;
        if (status.rd_kind == KIND_SAND || status.rd_kind == KIND_WATER) begin
          cmd.dir   = DIR_DOWN;
          state_nxt = ST_DOWN;
        end else begin
          state_nxt = ST_NEXT;
        end
      end
      ST_DOWN: begin
        if (status.in_down && rd_empty) begin
          tgt_nxt   = DIR_DOWN;
          state_nxt = ST_MOVE;
        end else if (kind_r == KIND_WATER) begin
          cmd.dir   = DIR_LEFT;
          state_nxt = ST_LEFT;
        end else begin
          cmd.dir   = DIR_DL;
          state_nxt = ST_DL;
        end
      end
      ST_LEFT: begin
        lfree_nxt = status.in_left && rd_empty;
        cmd.dir   = DIR_RIGHT;
        state_nxt = ST_RIGHT;
      end
      ST_RIGHT: begin
        // Water slides sideways only when exactly one side is open.
        if (lfree_r && !(status.in_right && rd_empty)) begin
          tgt_nxt   = DIR_LEFT;
          state_nxt = ST_MOVE;
        end else if (!lfree_r && status.in_right && rd_empty) begin
          tgt_nxt   = DIR_RIGHT;
          state_nxt = ST_MOVE;
        end else begin
          cmd.dir   = DIR_DL;
          state_nxt = ST_DL;
        end
      end
      ST_DL: begin
        if (status.in_down && status.in_left && rd_empty) begin
          tgt_nxt   = DIR_DL;
          state_nxt = ST_MOVE;
        end else begin
          cmd.dir   = DIR_DR;
          state_nxt = ST_DR;
        end
      end
      ST_DR: begin
        if (status.in_down && status.in_right && rd_empty) begin
          tgt_nxt   = DIR_DR;
          state_nxt = ST_MOVE;
        end else begin
          state_nxt = ST_NEXT;
        end
      end
      ST_MOVE: begin
        cmd.dir   = DIR_CENTER;
        cmd.we    = 1'b1;
        cmd.wkind = KIND_EMPTY;
        state_nxt = ST_PLACE;
      end
      ST_PLACE: begin
        cmd.dir   = tgt_r;
        cmd.we    = 1'b1;
        cmd.wkind = kind_r;
        state_nxt = ST_NEXT;
      end
      ST_NEXT: begin
        if (status.sw_last) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end else begin
          cmd.sw_adv = 1'b1;
          state_nxt  = ST_FETCH;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r  <= kind_nxt;
    tgt_r   <= tgt_nxt;
    lfree_r <= lfree_nxt;
  end

endmodule

FILE: rtl/falling_sand_grid_sweep_unit.sv
// ----------------------------------------------------------------------------
// falling_sand_grid_sweep_unit
// Falling-sand grid: cell write, cell read and one in-place gravity sweep.
// ----------------------------------------------------------------------------
// After reset the unit holds busy high while a clearing pass writes every
// cell of the grid to empty. An item is taken when start is high and busy is
// low; busy then stays high until the item's result has been issued, and the
// result appears on out_item for exactly one cycle with out_valid high, so the
// receiver must take it then. A sweep visits every cell, and a sand or water
// cell probes its neighbors one at a time and, when it moves, is cleared and
// then placed in its new cell. The sweep's pace is set by the single-port cell
// memory, which serves one read or one write per cycle.
module falling_sand_grid_sweep_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  fsgs_pkg::in_item_t   in_item,
  output logic                 out_valid,
  output fsgs_pkg::out_item_t  out_item
);
  import fsgs_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  fsgs_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .in_op (in_item.operation),
    .status(status),
    .cmd   (cmd),
    .busy  (busy)
  );

  fsgs_dpath u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .cmd      (cmd),
    .status   (status),
    .out_valid(out_valid),
    .out_item (out_item)
  );

endmodule

FILE: test/falling_sand_grid_sweep_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// falling_sand_grid_sweep_unit_tb
// Drives cell writes, cell reads, gravity sweeps and the unused operation code
// into the grid unit and checks every result against a behavioral grid model
// kept in the bench. The model updates at each accepted item, so reads after
// sweeps confirm how sand and water settled.
// ----------------------------------------------------------------------------
module falling_sand_grid_sweep_unit_tb;
  import fsgs_pkg::*;

  localparam logic [1:0] OP_UNUSED     = 2'd3;
  localparam int         SILENT_LIMIT  = 200000;
  localparam int         SETTLE_CYCLES = 40;
  localparam int         ROUNDS        = 4;

  typedef struct {
    in_item_t    item;
    int unsigned gap;
    bit          drain;
  } grid_request_t;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_valid;
  out_item_t out_item;

  logic [1:0]    grid_model [ROWS][COLS];
  grid_request_t pending_requests [$];
  out_item_t     grid_results_due [$];
  int            n_accepted;
  int            n_results;
  int            n_errors;
  int unsigned   gap_count;
  int            silent_cycles;

  falling_sand_grid_sweep_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  always #2 clk = ~clk;

  task automatic report_fault(input string msg);
    $display("%0t: mismatch: %s", $time, msg);
    n_errors++;
  endtask

  // A position outside the grid never counts as free.
  function automatic bit cell_free(input int r, input int c);
    if (r < 0 || r >= ROWS || c < 0 || c >= COLS) return 1'b0;
    return grid_model[r][c] == KIND_EMPTY;
  endfunction

  function automatic void move_particle(input int r, input int c, input int nr,
                                        input int nc);
    grid_model[nr][nc] = grid_model[r][c];
    grid_model[r][c]   = KIND_EMPTY;
  endfunction

  // Bottom row first, left to right, in place: a particle that moves right is
  // seen again later in the same row.
  function automatic void run_gravity_sweep();
    bit left_free;
    bit right_free;
    for (int r = ROWS - 1; r >= 0; r--) begin
      for (int c = 0; c < COLS; c++) begin
        if (grid_model[r][c] == KIND_SAND) begin
          if (cell_free(r + 1, c)) move_particle(r, c, r + 1, c);
          else if (cell_free(r + 1, c - 1)) move_particle(r, c, r + 1, c - 1);
          else if (cell_free(r + 1, c + 1)) move_particle(r, c, r + 1, c + 1);
        end else if (grid_model[r][c] == KIND_WATER) begin
          left_free  = cell_free(r, c - 1);
          right_free = cell_free(r, c + 1);
          if (cell_free(r + 1, c)) move_particle(r, c, r + 1, c);
          else if (left_free && !right_free) move_particle(r, c, r, c - 1);
          else if (right_free && !left_free) move_particle(r, c, r, c + 1);
          else if (cell_free(r + 1, c - 1)) move_particle(r, c, r + 1, c - 1);
          else if (cell_free(r + 1, c + 1)) move_particle(r, c, r + 1, c + 1);
        end
      end
    end
  endfunction

  function automatic out_item_t apply_grid_item(input in_item_t it);
    out_item_t res;
    bit        on_grid;
    res.read_kind          = KIND_EMPTY;
    res.finished_operation = it.operation;
    on_grid = int'(it.row) < ROWS && int'(it.column) < COLS;
    case (it.operation)
      OP_WRITE: if (on_grid) grid_model[it.row][it.column] = it.cell_kind;
      OP_READ:  if (on_grid) res.read_kind = grid_model[it.row][it.column];
      OP_SWEEP: run_gravity_sweep();
      default: ;
    endcase
    return res;
  endfunction

  task automatic queue_request(input logic [1:0] op, input int r, input int c,
                               input logic [1:0] kind, input bit burst,
                               input bit drain);
    grid_request_t req;
    req.item.operation = op;
    req.item.row       = r[5:0];
    req.item.column    = c[5:0];
    req.item.cell_kind = kind;
    req.gap            = burst ? 0 : $urandom_range(0, 12);
    req.drain          = drain;
    pending_requests.push_back(req);
  endtask

  function automatic logic [1:0] random_particle();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 4) return KIND_SAND;
    if (pick < 7) return KIND_WATER;
    if (pick < 8) return KIND_STATIC;
    return KIND_EMPTY;
  endfunction

  // Driver: launches the next queued item after its gap. An item marked for
  // draining waits until every earlier result has come back.
  always @(posedge clk) begin : driver
    bit took;
    if (!rst_n) begin
      start      <= 1'b0;
      in_item    <= '0;
      gap_count  <= 0;
      n_accepted <= 0;
    end else begin
      took = start && !busy;
      if (took) grid_results_due.push_back(apply_grid_item(in_item));
      if (start && !took) begin
        // Item still waiting for the unit.
      end else if (pending_requests.size() != 0 &&
                   gap_count >= pending_requests[0].gap &&
                   (!pending_requests[0].drain ||
                    (!took && n_accepted == n_results))) begin
        in_item   <= pending_requests[0].item;
        start     <= 1'b1;
        gap_count <= 0;
        pending_requests.pop_front();
      end else begin
        start     <= 1'b0;
        gap_count <= gap_count + 1;
      end
      if (took) n_accepted <= n_accepted + 1;
    end
  end

  always @(posedge clk) begin : monitor
    out_item_t want;
    if (!rst_n) begin
      n_results <= 0;
    end else if (out_valid) begin
      n_results <= n_results + 1;
      if (grid_results_due.size() == 0) begin
        report_fault($sformatf("result with nothing expected (read_kind %0d, op %0d)",
                               out_item.read_kind, out_item.finished_operation));
      end else begin
        want = grid_results_due.pop_front();
        if (out_item.read_kind !== want.read_kind)
          report_fault($sformatf("read_kind %0d, expected %0d",
                                 out_item.read_kind, want.read_kind));
        if (out_item.finished_operation !== want.finished_operation)
          report_fault($sformatf("finished_operation %0d, expected %0d",
                                 out_item.finished_operation,
                                 want.finished_operation));
      end
    end
  end

  // Counts cycles in which neither an item nor a result moves.
  always @(posedge clk) begin : watchdog
    if (!rst_n || (start && !busy) || out_valid) begin
      silent_cycles <= 0;
    end else if (silent_cycles >= SILENT_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      silent_cycles <= silent_cycles + 1;
    end
  end

  initial begin
    int r0;
    int c0;
    int r;
    int c;
    int n_writes;
    int n_reads;
    int n_noise;
    int n_sweeps;
    bit burst;

    clk           = 1'b0;
    rst_n         = 1'b0;
    n_errors      = 0;
    foreach (grid_model[i, j]) grid_model[i][j] = KIND_EMPTY;

    // Directed scene on the two bottom rows: sand falling straight, down-left
    // and down-right at both side edges, water sliding left, and water sliding
    // right and then falling when it is visited again in the same sweep.
    queue_request(OP_READ, 0, 0, KIND_EMPTY, 1'b0, 1'b0);
    queue_request(OP_READ, 63, 63, KIND_EMPTY, 1'b0, 1'b0);
    queue_request(OP_UNUSED, 63, 63, KIND_STATIC, 1'b0, 1'b0);
    queue_request(OP_WRITE, 62, 0, KIND_SAND, 1'b1, 1'b0);
    queue_request(OP_WRITE, 63, 2, KIND_STATIC, 1'b1, 1'b0);
    queue_request(OP_WRITE, 62, 2, KIND_SAND, 1'b1, 1'b0);
    queue_request(OP_WRITE, 63, 63, KIND_STATIC, 1'b0, 1'b0);
    queue_request(OP_WRITE, 62, 63, KIND_SAND, 1'b0, 1'b0);
    queue_request(OP_WRITE, 63, 60, KIND_STATIC, 1'b0, 1'b0);
    queue_request(OP_WRITE, 63, 59, KIND_STATIC, 1'b0, 1'b0);
    queue_request(OP_WRITE, 62, 60, KIND_SAND, 1'b0, 1'b0);
    queue_request(OP_WRITE, 63, 10, KIND_STATIC, 1'b1, 1'b0);
    queue_request(OP_WRITE, 62, 11, KIND_STATIC, 1'b1, 1'b0);
    queue_request(OP_WRITE, 62, 10, KIND_WATER, 1'b1, 1'b0);
    queue_request(OP_WRITE, 63, 20, KIND_STATIC, 1'b0, 1'b0);
    queue_request(OP_WRITE, 62, 19, KIND_STATIC, 1'b0, 1'b0);
    queue_request(OP_WRITE, 62, 20, KIND_WATER, 1'b0, 1'b0);
    queue_request(OP_SWEEP, 0, 0, KIND_EMPTY, 1'b0, 1'b1);
    queue_request(OP_READ, 63, 0, KIND_EMPTY, 1'b0, 1'b0);
    queue_request(OP_READ, 63, 1, KIND_EMPTY, 1'b0, 1'b0);
    queue_request(OP_READ, 63, 61, KIND_EMPTY, 1'b1, 1'b0);
    queue_request(OP_READ, 63, 62, KIND_EMPTY, 1'b1, 1'b0);
    queue_request(OP_READ, 62, 9, KIND_EMPTY, 1'b1, 1'b0);
    queue_request(OP_READ, 63, 21, KIND_EMPTY, 1'b0, 1'b0);
    queue_request(OP_READ, 62, 20, KIND_EMPTY, 1'b0, 1'b0);

    // Random rounds: crowd a small window so particles collide, sweep, then
    // read the window back. A little noise with any field value is mixed in.
    for (int round = 0; round < ROUNDS; round++) begin
      burst = ($urandom_range(0, 2) == 0);
      case ($urandom_range(0, 2))
        0:       r0 = 0;
        1:       r0 = ROWS - 4;
        default: r0 = $urandom_range(0, ROWS - 4);
      endcase
      case ($urandom_range(0, 2))
        0:       c0 = 0;
        1:       c0 = COLS - 8;
        default: c0 = $urandom_range(0, COLS - 8);
      endcase
      n_writes = $urandom_range(8, 12);
      for (int k = 0; k < n_writes; k++) begin
        r = r0 + $urandom_range(0, 3);
        c = c0 + $urandom_range(0, 7);
        queue_request(OP_WRITE, r, c, random_particle(), burst, 1'b0);
      end
      n_noise = $urandom_range(0, 2);
      for (int k = 0; k < n_noise; k++)
        queue_request(2'($urandom_range(0, 3)), $urandom_range(0, 63),
                      $urandom_range(0, 63), 2'($urandom_range(0, 3)), burst, 1'b0);
      n_sweeps = $urandom_range(1, 2);
      for (int k = 0; k < n_sweeps; k++)
        queue_request(OP_SWEEP, $urandom_range(0, 63), $urandom_range(0, 63),
                      2'($urandom_range(0, 3)), burst, k == 0 && round % 3 == 0);
      n_reads = $urandom_range(4, 6);
      for (int k = 0; k < n_reads; k++) begin
        r = r0 + $urandom_range(0, 4);
        if (r >= ROWS) r = ROWS - 1;
        c = c0 + $urandom_range(0, 7);
        queue_request(OP_READ, r, c, 2'($urandom_range(0, 3)), burst, 1'b0);
      end
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    do @(negedge clk);
    while (pending_requests.size() != 0 || start || n_results != n_accepted);
    repeat (SETTLE_CYCLES) @(negedge clk);

    if (grid_results_due.size() != 0)
      report_fault($sformatf("%0d results never arrived", grid_results_due.size()));
    if (n_errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
